[hw/rtl/mwc_pkg.sv]
// Shared types and constants for the lag-based multiply-with-carry byte generator.
// Used by mwc_mac, mwc_seq, the top level and the testbench; depends on nothing else.
`default_nettype none

package mwc_pkg;

  // Operation codes carried by in_opcode.
  localparam logic [1:0] OP_GENERATE = 2'd0;
  localparam logic [1:0] OP_ABSORB   = 2'd1;
  localparam logic [1:0] OP_FINISH   = 2'd2;

  // Generator multiplier halves and hash constants.
  localparam logic [7:0]  MULT_LO   = 8'h17;
  localparam logic [7:0]  MULT_HI   = 8'hdc;
  localparam logic [15:0] MIX_INIT  = 16'h5555;
  localparam logic [7:0]  MIX_MUL   = 8'he9;
  localparam logic [7:0]  CARRY_TOP = 8'h55;
  localparam int          MIX_SHIFT = 11;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX_RD,
    ST_MIX_ADD,
    ST_MIX_MUL,
    ST_GEN_RD0,
    ST_GEN_M0,
    ST_GEN_M1,
    ST_GEN_M2,
    ST_GEN_M3
  } state_t;

  // Operands for the shared multiply-add unit: res = (a * b + addend) mod 2^16.
  typedef struct packed {
    logic [15:0] a;
    logic [7:0]  b;
    logic [15:0] addend;
  } mac_req_t;

endpackage

`default_nettype wire

[hw/rtl/mwc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
`default_nettype none

module mwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

[hw/rtl/mwc_mac.sv]
// Shared 16 by 8 multiply-add unit used by both the generator and the seed hash.
// Depends on mwc_pkg for the operand struct.
`default_nettype none

module mwc_mac (
  input  wire mwc_pkg::mac_req_t req,
  output logic [15:0]            res
);

  logic [23:0] prod;

  // Only the low 16 bits of the product and sum are kept.
  assign prod = {8'b0, req.a} * {16'b0, req.b};
  assign res  = prod[15:0] + req.addend;

endmodule

`default_nettype wire

[hw/rtl/mwc_seq.sv]
// Sequencer and working registers: hash rounds, seeding control and generator steps.
// Depends on mwc_pkg; drives the ring RAM ports and the shared multiply-add unit.
`default_nettype none

module mwc_seq #(
  parameter int LAG = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [1:0]              in_opcode,
  input  wire logic [7:0]              in_seed_byte,
  output logic                         in_ready,
  input  wire logic                    out_free,
  output logic                         gen_done,
  output logic [15:0]                  gen_value,
  output logic [$clog2(LAG)-1:0]       ring_rd_addr,
  input  wire logic [7:0]              ring_rd_data,
  output logic                         ring_wr_en,
  output logic [$clog2(LAG)-1:0]       ring_wr_addr,
  output logic [7:0]                   ring_wr_data,
  output mwc_pkg::mac_req_t            mac_req,
  input  wire logic [15:0]             mac_res
);

  localparam int ADDR_W   = $clog2(LAG);
  localparam int PAIRS    = (LAG + 1) / 2;
  localparam int POS_W    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CNT_W    = $clog2(LAG + 1);
  localparam logic [7:0] LAG_B    = 8'(LAG);
  localparam logic [7:0] SEED_CAP = 8'(255 - LAG);

  mwc_pkg::state_t     state_r, state_nxt;
  logic [15:0]         acc_r, acc_nxt;
  logic [7:0]          rnd_r, rnd_nxt;
  logic [ADDR_W-1:0]   slot_r, slot_nxt;
  logic                seeding_r, seeding_nxt;
  logic [15:0]         carry_r, carry_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    fin_r, fin_nxt;
  logic                absorb_r, absorb_nxt;
  logic                gen_r, gen_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [7:0]          xy_r, xy_nxt;
  logic [15:0]         t_r, t_nxt;
  logic [7:0]          lo_r, lo_nxt;
  logic [15:0]         pre_r, pre_nxt;

  logic                accept;
  logic                can_absorb;
  logic [ADDR_W-1:0]   p0, p1;
  logic [ADDR_W:0]     two_q1;
  logic [ADDR_W:0]     two_q2;
  logic [15:0]         mix_sum;

  assign in_ready = (state_r == mwc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  // A fresh seeding always has room; an ongoing one stops at the byte cap.
  assign can_absorb = !seeding_r || (rnd_r < SEED_CAP);

  // Ring slots of the current byte pair, with wrap for an odd lag.
  assign two_q1 = (ADDR_W + 1)'({pos_r, 1'b1});
  assign two_q2 = (ADDR_W + 1)'({pos_r, 1'b0}) + (ADDR_W + 1)'(2);
  assign p0     = ADDR_W'({pos_r, 1'b0});
  assign p1     = (two_q1 == (ADDR_W + 1)'(LAG)) ? '0 : two_q1[ADDR_W-1:0];

  // Hash round input: counter, seed byte when absorbing and, once the counter exceeds LAG, the old slot byte.
  assign mix_sum = acc_r + {8'b0, rnd_r}
                 + (absorb_r ? {8'b0, byte_r} : 16'b0)
                 + ((rnd_r > LAG_B) ? {ring_rd_data, 8'b0} : 16'b0);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mwc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            mwc_pkg::OP_ABSORB: begin
              if (can_absorb) begin
                state_nxt = mwc_pkg::ST_MIX_RD;
              end
            end
            mwc_pkg::OP_FINISH: state_nxt = mwc_pkg::ST_MIX_RD;
            mwc_pkg::OP_GENERATE: begin
              state_nxt = seeding_r ? mwc_pkg::ST_MIX_RD : mwc_pkg::ST_GEN_RD0;
            end
            default: state_nxt = mwc_pkg::ST_IDLE;
          endcase
        end
      end
      mwc_pkg::ST_MIX_RD:  state_nxt = mwc_pkg::ST_MIX_ADD;
      mwc_pkg::ST_MIX_ADD: state_nxt = mwc_pkg::ST_MIX_MUL;
      mwc_pkg::ST_MIX_MUL: begin
        if (absorb_r) begin
          state_nxt = mwc_pkg::ST_IDLE;
        end else if (fin_r == CNT_W'(1)) begin
          state_nxt = gen_r ? mwc_pkg::ST_GEN_RD0 : mwc_pkg::ST_IDLE;
        end else begin
          state_nxt = mwc_pkg::ST_MIX_RD;
        end
      end
      mwc_pkg::ST_GEN_RD0: state_nxt = mwc_pkg::ST_GEN_M0;
      mwc_pkg::ST_GEN_M0:  state_nxt = mwc_pkg::ST_GEN_M1;
      mwc_pkg::ST_GEN_M1:  state_nxt = mwc_pkg::ST_GEN_M2;
      mwc_pkg::ST_GEN_M2:  state_nxt = mwc_pkg::ST_GEN_M3;
      mwc_pkg::ST_GEN_M3: begin
        if (out_free) begin
          state_nxt = mwc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mwc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    acc_nxt      = acc_r;
    rnd_nxt      = rnd_r;
    slot_nxt     = slot_r;
    seeding_nxt  = seeding_r;
    carry_nxt    = carry_r;
    pos_nxt      = pos_r;
    fin_nxt      = fin_r;
    absorb_nxt   = absorb_r;
    gen_nxt      = gen_r;
    byte_nxt     = byte_r;
    xy_nxt       = xy_r;
    t_nxt        = t_r;
    lo_nxt       = lo_r;
    pre_nxt      = pre_r;
    ring_rd_addr = slot_r;
    ring_wr_en   = 1'b0;
    ring_wr_addr = slot_r;
    ring_wr_data = mac_res[15:8];
    mac_req      = '{a: pre_r, b: mwc_pkg::MIX_MUL, addend: 16'b0};
    gen_done     = 1'b0;
    gen_value    = {t_r[7:0], lo_r};

    case (state_r)
      mwc_pkg::ST_IDLE: begin
        if (accept) begin
          // Absorb and finish start a fresh hash when no seeding is under way.
          if ((in_opcode == mwc_pkg::OP_ABSORB || in_opcode == mwc_pkg::OP_FINISH)
              && !seeding_r) begin
            acc_nxt     = mwc_pkg::MIX_INIT;
            rnd_nxt     = 8'd0;
            slot_nxt    = '0;
            seeding_nxt = 1'b1;
          end
          absorb_nxt = (in_opcode == mwc_pkg::OP_ABSORB);
          gen_nxt    = (in_opcode == mwc_pkg::OP_GENERATE);
          byte_nxt   = in_seed_byte;
          fin_nxt    = CNT_W'(LAG);
        end
      end
      mwc_pkg::ST_MIX_RD: begin
        ring_rd_addr = slot_r;
      end
      mwc_pkg::ST_MIX_ADD: begin
        pre_nxt = mix_sum ^ (mix_sum >> mwc_pkg::MIX_SHIFT);
      end
      mwc_pkg::ST_MIX_MUL: begin
        // One hash round: multiply, write the high byte back, advance the slot.
        acc_nxt      = mac_res;
        ring_wr_en   = 1'b1;
        ring_wr_addr = slot_r;
        ring_wr_data = mac_res[15:8];
        rnd_nxt      = rnd_r + 8'd1;
        slot_nxt     = (slot_r == ADDR_W'(LAG - 1)) ? '0 : slot_r + ADDR_W'(1);
        if (!absorb_r) begin
          fin_nxt = fin_r - CNT_W'(1);
          if (fin_r == CNT_W'(1)) begin
            carry_nxt   = {mwc_pkg::CARRY_TOP, mac_res[7:0]};
            pos_nxt     = '0;
            seeding_nxt = 1'b0;
          end
        end
      end
      mwc_pkg::ST_GEN_RD0: begin
        ring_rd_addr = p0;
      end
      mwc_pkg::ST_GEN_M0: begin
        // First byte, low multiplier half plus incoming carry.
        ring_rd_addr = p1;
        xy_nxt       = ring_rd_data;
        mac_req      = '{a: {8'b0, ring_rd_data}, b: mwc_pkg::MULT_LO, addend: carry_r};
        t_nxt        = mac_res;
      end
      mwc_pkg::ST_GEN_M1: begin
        // First byte, high multiplier half plus the upper part of t.
        mac_req      = '{a: {8'b0, xy_r}, b: mwc_pkg::MULT_HI, addend: {8'b0, t_r[15:8]}};
        carry_nxt    = mac_res;
        ring_wr_en   = 1'b1;
        ring_wr_addr = p0;
        ring_wr_data = t_r[7:0];
        lo_nxt       = t_r[7:0];
        xy_nxt       = ring_rd_data;
      end
      mwc_pkg::ST_GEN_M2: begin
        mac_req = '{a: {8'b0, xy_r}, b: mwc_pkg::MULT_LO, addend: carry_r};
        t_nxt   = mac_res;
      end
      mwc_pkg::ST_GEN_M3: begin
        // Second byte; held until the output register can take the value.
        mac_req = '{a: {8'b0, xy_r}, b: mwc_pkg::MULT_HI, addend: {8'b0, t_r[15:8]}};
        if (out_free) begin
          carry_nxt    = mac_res;
          ring_wr_en   = 1'b1;
          ring_wr_addr = p1;
          ring_wr_data = t_r[7:0];
          gen_done     = 1'b1;
          pos_nxt      = (two_q2 >= (ADDR_W + 1)'(LAG)) ? '0 : pos_r + POS_W'(1);
        end
      end
      default: begin
        ring_rd_addr = slot_r;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mwc_pkg::ST_IDLE;
      seeding_r <= 1'b0;
      carry_r   <= 16'b0;
      pos_r     <= '0;
      acc_r     <= mwc_pkg::MIX_INIT;
      rnd_r     <= 8'd0;
      slot_r    <= '0;
      fin_r     <= '0;
      absorb_r  <= 1'b0;
      gen_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seeding_r <= seeding_nxt;
      carry_r   <= carry_nxt;
      pos_r     <= pos_nxt;
      acc_r     <= acc_nxt;
      rnd_r     <= rnd_nxt;
      slot_r    <= slot_nxt;
      fin_r     <= fin_nxt;
      absorb_r  <= absorb_nxt;
      gen_r     <= gen_nxt;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    xy_r   <= xy_nxt;
    t_r    <= t_nxt;
    lo_r   <= lo_nxt;
    pre_r  <= pre_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/mwc_lag8_byte_random_generator.sv]
// Top level of the lag-based multiply-with-carry byte generator.
// Depends on mwc_pkg, mwc_ram, mwc_mac and mwc_seq.
`default_nettype none

// A generate transfer (opcode 0) yields one 16-bit value, the second updated ring
// byte in the high half; absorb (1) feeds a seed byte into the hash and finish (2)
// closes seeding with LAG extra rounds, neither giving a result. Items are handled
// one at a time through a single shared 16 by 8 multiply-add unit and one read port
// on the ring RAM: a hash round reads, adds and multiplies; a generate first runs
// any closing rounds if seeding is open, then reads and runs a low-half and a
// high-half multiply for each byte. A finished value waits in an output register,
// and the next item is taken meanwhile; a generate only stalls in its last step if
// the previous value is still unclaimed. The ring reads as zero after reset.
module mwc_lag8_byte_random_generator #(
  parameter int LAG = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_seed_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_random_value
);

  localparam int ADDR_W = $clog2(LAG);

  logic [ADDR_W-1:0]  ring_rd_addr;
  logic [7:0]         ring_q;
  logic [7:0]         ring_rd_data;
  logic               ring_wr_en;
  logic [ADDR_W-1:0]  ring_wr_addr;
  logic [7:0]         ring_wr_data;
  logic [LAG-1:0]     vld_r;
  logic               rd_vld_r;
  mwc_pkg::mac_req_t  mac_req;
  logic [15:0]        mac_res;
  logic               gen_done;
  logic [15:0]        gen_value;
  logic               out_free;
  logic               out_valid_r;
  logic [15:0]        out_value_r;

  assign out_free         = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

  // Ring entries never written since reset read as zero.
  assign ring_rd_data = rd_vld_r ? ring_q : 8'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[ring_rd_addr];
      if (ring_wr_en) begin
        vld_r[ring_wr_addr] <= 1'b1;
      end
    end
  end

  // Output register; a new value lands only when the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (gen_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_done) begin
      out_value_r <= gen_value;
    end
  end

  mwc_ram #(
    .WIDTH (8),
    .DEPTH (LAG)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (ring_wr_addr),
    .wr_data (ring_wr_data),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_q)
  );

  mwc_mac u_mac (
    .req (mac_req),
    .res (mac_res)
  );

  mwc_seq #(
    .LAG (LAG)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_opcode    (in_opcode),
    .in_seed_byte (in_seed_byte),
    .in_ready     (in_ready),
    .out_free     (out_free),
    .gen_done     (gen_done),
    .gen_value    (gen_value),
    .ring_rd_addr (ring_rd_addr),
    .ring_rd_data (ring_rd_data),
    .ring_wr_en   (ring_wr_en),
    .ring_wr_addr (ring_wr_addr),
    .ring_wr_data (ring_wr_data),
    .mac_req      (mac_req),
    .mac_res      (mac_res)
  );

endmodule

`default_nettype wire

[dv/mwc_lag8_byte_random_generator_tb.sv]
// Self-checking testbench for the lag-8 multiply-with-carry byte generator.
// Holds its own predictor of the ring, carry and seed hash; depends on mwc_pkg and the RTL.
`timescale 1ns / 100ps

module mwc_lag8_byte_random_generator_tb;

  localparam int HALF_PERIOD = 4;
  localparam int RING_LAG = 8;
  localparam int SEED_LIMIT = 255 - RING_LAG;
  // Longest item is a generate that closes an open seeding.
  localparam int DRAIN_CYCLES = 3 * RING_LAG + 8;
  localparam int RUN_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 205;
  // Opcode 3 has no meaning; the block must ignore it.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [7:0]  in_seed_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_random_value;

  // Idling controls, changed between phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int fail_count = 0;
  int items_sent = 0;
  int cycle_count = 0;

  // Values still owed by the block, oldest first.
  logic [15:0] expected_values[$];

  // Predictor state.
  logic [7:0]  ring_bytes[RING_LAG];
  logic [15:0] mwc_carry;
  int unsigned pair_idx;
  logic [15:0] hash_acc;
  logic [7:0]  hash_rounds;
  bit          seeding_open;

  mwc_lag8_byte_random_generator #(
    .LAG(RING_LAG)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_seed_byte     (in_seed_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("** mwc_lag8_byte_random_generator: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_predictor();
    for (int i = 0; i < RING_LAG; i++) ring_bytes[i] = 8'h00;
    mwc_carry = 16'h0000;
    pair_idx = 0;
    hash_acc = mwc_pkg::MIX_INIT;
    hash_rounds = 8'h00;
    seeding_open = 1'b0;
  endfunction

  // One round of the seed hash, writing its top byte into the ring.
  function automatic void hash_round(input bit absorbing, input logic [7:0] seed);
    int unsigned r;
    int unsigned slot;
    logic [15:0] acc;
    r = hash_rounds;
    slot = r % RING_LAG;
    acc = hash_acc + 16'(r);
    if (absorbing) acc = acc + 16'(seed);
    if (r > RING_LAG) acc = acc + {ring_bytes[slot], 8'h00};
    acc = (acc ^ (acc >> mwc_pkg::MIX_SHIFT)) * 16'(mwc_pkg::MIX_MUL);
    ring_bytes[slot] = acc[15:8];
    hash_acc = acc;
    hash_rounds = hash_rounds + 8'd1;
  endfunction

  function automatic void open_seeding();
    hash_acc = mwc_pkg::MIX_INIT;
    hash_rounds = 8'h00;
    seeding_open = 1'b1;
  endfunction

  // Closing seeding runs LAG blank rounds and loads the carry from the hash.
  function automatic void close_seeding();
    if (!seeding_open) open_seeding();
    for (int k = 0; k < RING_LAG; k++) hash_round(1'b0, 8'h00);
    mwc_carry = {mwc_pkg::CARRY_TOP, hash_acc[7:0]};
    pair_idx = 0;
    seeding_open = 1'b0;
  endfunction

  // One multiply-with-carry byte update, chaining through mwc_carry.
  function automatic logic [7:0] mwc_byte(input logic [7:0] x);
    logic [15:0] t;
    t = 16'(mwc_pkg::MULT_LO) * 16'(x) + mwc_carry;
    mwc_carry = (t >> 8) + 16'(mwc_pkg::MULT_HI) * 16'(x);
    return t[7:0];
  endfunction

  function automatic void predict_item(input logic [1:0] op, input logic [7:0] seed);
    int unsigned p0;
    int unsigned p1;
    logic [7:0] lo;
    logic [7:0] hi;
    case (op)
      mwc_pkg::OP_ABSORB: begin
        if (!seeding_open) open_seeding();
        if (hash_rounds < 8'(SEED_LIMIT)) hash_round(1'b1, seed);
      end
      mwc_pkg::OP_FINISH: begin
        close_seeding();
      end
      mwc_pkg::OP_GENERATE: begin
        if (seeding_open) close_seeding();
        p0 = (2 * pair_idx) % RING_LAG;
        p1 = (2 * pair_idx + 1) % RING_LAG;
        lo = mwc_byte(ring_bytes[p0]);
        hi = mwc_byte(ring_bytes[p1]);
        ring_bytes[p0] = lo;
        ring_bytes[p1] = hi;
        pair_idx = pair_idx + 1;
        if (2 * pair_idx >= RING_LAG) pair_idx = 0;
        expected_values.push_back({hi, lo});
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and comparison against the predictor
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    logic [15:0] want;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_values.size() == 0) begin
        $error("random_value: no value expected, got %h", out_random_value);
        fail_count++;
      end else begin
        want = expected_values.pop_front();
        if (out_random_value !== want) begin
          $error("random_value: expected %h, got %h", want, out_random_value);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Presents one item, idling first at random, and returns once the transfer is made.
  task automatic send_item(input logic [1:0] op, input logic [7:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_seed_byte <= seed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(op, seed);
    if (op != OP_RESERVED) items_sent++;
  endtask

  // Holds off the sender until every owed value is back and the block has settled.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The ring and carry are zero after reset, so the first full lap reads zero.
  task automatic test_generate_after_reset();
    repeat (5) send_item(mwc_pkg::OP_GENERATE, 8'h00);
  endtask

  // Absorb while idle opens seeding; seed bytes at both extremes.
  task automatic test_seed_byte_extremes();
    send_item(mwc_pkg::OP_ABSORB, 8'h00);
    send_item(mwc_pkg::OP_ABSORB, 8'hff);
    send_item(mwc_pkg::OP_ABSORB, 8'h80);
    send_item(mwc_pkg::OP_ABSORB, 8'h7f);
    send_item(mwc_pkg::OP_FINISH, 8'hff);
    send_item(mwc_pkg::OP_GENERATE, 8'hff);
    send_item(mwc_pkg::OP_GENERATE, 8'h00);
  endtask

  // Opcode 3 must leave the state untouched and give no value.
  task automatic test_reserved_opcode();
    send_item(OP_RESERVED, 8'hff);
    send_item(mwc_pkg::OP_GENERATE, 8'h55);
    send_item(OP_RESERVED, 8'h00);
    send_item(mwc_pkg::OP_GENERATE, 8'haa);
  endtask

  // Finishing with no seeding open acts as an empty seed.
  task automatic test_finish_while_idle();
    send_item(mwc_pkg::OP_FINISH, 8'h00);
    send_item(mwc_pkg::OP_GENERATE, 8'h00);
    send_item(mwc_pkg::OP_GENERATE, 8'h00);
  endtask

  // A generate during seeding closes the seed first.
  task automatic test_generate_closes_seeding();
    send_item(mwc_pkg::OP_ABSORB, 8'h5a);
    send_item(mwc_pkg::OP_ABSORB, 8'ha5);
    send_item(mwc_pkg::OP_GENERATE, 8'h00);
    send_item(mwc_pkg::OP_GENERATE, 8'hff);
  endtask

  // Seed bytes past the cap are dropped; run with some idling on both sides.
  task automatic test_seed_overflow();
    wait_drained();
    send_idle_pct = 11;
    recv_stall_pct = 11;
    repeat (SEED_LIMIT + 5) send_item(mwc_pkg::OP_ABSORB, 8'($urandom_range(255)));
    send_item(mwc_pkg::OP_GENERATE, 8'h00);
    send_item(mwc_pkg::OP_GENERATE, 8'h00);
    send_item(mwc_pkg::OP_ABSORB, 8'h01);
    send_item(mwc_pkg::OP_FINISH, 8'h00);
    send_item(mwc_pkg::OP_GENERATE, 8'h00);
    wait_drained();
  endtask

  // Mostly seed-then-generate sequences with random content, some random noise.
  task automatic run_random_traffic(input int idle_pct, input int stall_pct);
    int stop_at;
    int n_abs;
    int n_gen;
    int n_noise;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + ITEMS_PER_PHASE;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 8) begin
        n_abs = $urandom_range(12);
        repeat (n_abs) send_item(mwc_pkg::OP_ABSORB, 8'($urandom_range(255)));
        if ($urandom_range(1) == 1) begin
          send_item(mwc_pkg::OP_FINISH, 8'($urandom_range(255)));
        end
        n_gen = $urandom_range(1, 10);
        repeat (n_gen) send_item(mwc_pkg::OP_GENERATE, 8'($urandom_range(255)));
      end else begin
        n_noise = $urandom_range(1, 6);
        repeat (n_noise) send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
    // The sender pauses until every owed value has come back.
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    run_random_traffic(0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random_traffic(61, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random_traffic(0, 61);
  endtask

  task automatic test_random_both_idle();
    run_random_traffic(11, 11);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    in_valid <= 1'b0;
    in_opcode <= mwc_pkg::OP_GENERATE;
    in_seed_byte <= 8'h00;
    rst_n <= 1'b0;
    clear_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_generate_after_reset();
    test_seed_byte_extremes();
    test_reserved_opcode();
    test_finish_while_idle();
    test_generate_closes_seeding();
    test_seed_overflow();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    wait_drained();
    if (expected_values.size() != 0) begin
      $error("random_value: %0d expected values never arrived", expected_values.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** mwc_lag8_byte_random_generator: PASSED **");
    end else begin
      $display("** mwc_lag8_byte_random_generator: FAILED **");
    end
    $finish;
  end

endmodule
